// ===== src/i2cram_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cram_pkg
// Types, codes and segment plan for the I2C register access master.
// ----------------------------------------------------------------------------
package i2cram_pkg;

  // request selector
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // byte sources for a send segment
  localparam logic [1:0] SRC_DEVICE   = 2'd0;
  localparam logic [1:0] SRC_REGISTER = 2'd1;
  localparam logic [1:0] SRC_DATA     = 2'd2;
  localparam logic [1:0] SRC_DEV_RD   = 2'd3;

  localparam logic       KIND_WRITE = 1'b0;
  localparam logic       KIND_READ  = 1'b1;

  localparam logic [7:0] RD_BIT_MASK = 8'h01;
  localparam logic [7:0] MSB_MASK    = 8'h80;

  typedef enum logic [2:0] {
    SEG_START,
    SEG_SEND,
    SEG_ACK,
    SEG_RECV,
    SEG_NACK,
    SEG_STOP
  } seg_kind_t;

  // decoded position inside the transaction plan
  typedef struct packed {
    logic      hit;   // step lies inside the plan
    seg_kind_t kind;
    logic [1:0] arg;  // byte source or ack record bit
    logic [4:0] off;  // phase offset inside the segment
  } seg_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] device_byte;
    logic [7:0] register_address;
    logic [7:0] write_data;
    logic       sda_in;
  } in_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic [2:0] ack_bits;
  } out_t;

endpackage

// ===== src/i2cram_seg_decode.sv =====
// ----------------------------------------------------------------------------
// i2cram_seg_decode
// Maps the phase step counter onto the segment plan of a write or a read.
// ----------------------------------------------------------------------------
module i2cram_seg_decode import i2cram_pkg::*; (
  input  logic       kind,
  input  logic [6:0] phase_step,
  output seg_t       seg
);

  function automatic seg_t mk(seg_kind_t k, logic [1:0] a, logic [6:0] step,
                              logic [6:0] base);
    seg_t s;
    logic [6:0] d;
    d      = step - base;
    s.hit  = 1'b1;
    s.kind = k;
    s.arg  = a;
    s.off  = d[4:0];
    return s;
  endfunction

  always_comb begin
    seg = '{hit: 1'b0, kind: SEG_STOP, arg: 2'd0, off: 5'd0};
    if (kind == KIND_WRITE) begin
      if (phase_step < 7'd4)        seg = mk(SEG_START, 2'd0, phase_step, 7'd0);
      else if (phase_step < 7'd28)  seg = mk(SEG_SEND, SRC_DEVICE, phase_step, 7'd4);
      else if (phase_step < 7'd31)  seg = mk(SEG_ACK, 2'd0, phase_step, 7'd28);
      else if (phase_step < 7'd55)  seg = mk(SEG_SEND, SRC_REGISTER, phase_step, 7'd31);
      else if (phase_step < 7'd58)  seg = mk(SEG_ACK, 2'd1, phase_step, 7'd55);
      else if (phase_step < 7'd82)  seg = mk(SEG_SEND, SRC_DATA, phase_step, 7'd58);
      else if (phase_step < 7'd85)  seg = mk(SEG_ACK, 2'd2, phase_step, 7'd82);
      else if (phase_step < 7'd88)  seg = mk(SEG_STOP, 2'd0, phase_step, 7'd85);
    end else begin
      if (phase_step < 7'd4)        seg = mk(SEG_START, 2'd0, phase_step, 7'd0);
      else if (phase_step < 7'd28)  seg = mk(SEG_SEND, SRC_DEVICE, phase_step, 7'd4);
      else if (phase_step < 7'd31)  seg = mk(SEG_ACK, 2'd0, phase_step, 7'd28);
      else if (phase_step < 7'd55)  seg = mk(SEG_SEND, SRC_REGISTER, phase_step, 7'd31);
      else if (phase_step < 7'd58)  seg = mk(SEG_ACK, 2'd1, phase_step, 7'd55);
      else if (phase_step < 7'd62)  seg = mk(SEG_START, 2'd0, phase_step, 7'd58);
      else if (phase_step < 7'd86)  seg = mk(SEG_SEND, SRC_DEV_RD, phase_step, 7'd62);
      else if (phase_step < 7'd89)  seg = mk(SEG_ACK, 2'd2, phase_step, 7'd86);
      else if (phase_step < 7'd106) seg = mk(SEG_RECV, 2'd0, phase_step, 7'd89);
      else if (phase_step < 7'd109) seg = mk(SEG_NACK, 2'd0, phase_step, 7'd106);
      else if (phase_step < 7'd112) seg = mk(SEG_STOP, 2'd0, phase_step, 7'd109);
    end
  end

endmodule

// ===== src/i2c_register_access_master_unit.sv =====
// ----------------------------------------------------------------------------
// i2c_register_access_master_unit
// Open-drain I2C master for single register writes and reads, one pin
// phase per tick transfer. A write runs 88 ticks, a read 112.
// Each item passes through an input register, then a result register.
// One item per cycle while the output side does not stall.
// Reset: sequencer idle, SCL and SDA released, latched bytes cleared.
// ----------------------------------------------------------------------------
module i2c_register_access_master_unit import i2cram_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic       in_vq;
  in_t        in_q;
  logic       advance;

  logic [6:0] phase_step, phase_step_next;
  logic       transaction_kind, transaction_kind_next;
  logic       active, active_next;
  logic [7:0] latched_device, latched_device_next;
  logic [7:0] latched_register, latched_register_next;
  logic [7:0] latched_data, latched_data_next;
  logic [7:0] received_byte, received_byte_next;
  logic [2:0] ack_record, ack_record_next;
  logic       scl_level, scl_level_next;
  logic       sda_level, sda_level_next;
  logic       done_next;

  seg_t       seg;
  logic [7:0] send_byte;
  logic [4:0] bit_mul;
  logic [9:0] mul11;
  logic [2:0] bit_idx;
  logic [4:0] bit_x3;
  logic [4:0] rem3;
  logic [4:0] rx_k;
  logic [2:0] rx_bit;

  assign advance  = in_vq && (!out_valid || !out_stall);
  assign in_stall = in_vq && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vq <= 1'b0;
    end else if (!in_stall) begin
      in_vq <= in_valid;
    end
    if (in_valid && !in_stall) begin
      in_q <= in_data;
    end
  end

  i2cram_seg_decode u_decode (
    .kind       (transaction_kind),
    .phase_step (phase_step),
    .seg        (seg)
  );

  // offset / 3 for offsets below 24: (off * 11) >> 5
  assign bit_mul = seg.off;
  assign mul11   = {5'd0, bit_mul} * 10'd11;
  assign bit_idx = mul11[7:5];
  assign bit_x3  = {1'b0, bit_idx, 1'b0} + {2'd0, bit_idx};
  assign rem3    = seg.off - bit_x3;
  assign rx_k    = seg.off - 5'd1;
  assign rx_bit  = rx_k[3:1];

  always_comb begin
    case (seg.arg)
      SRC_DEVICE:   send_byte = latched_device;
      SRC_REGISTER: send_byte = latched_register;
      SRC_DATA:     send_byte = latched_data;
      default:      send_byte = latched_device | RD_BIT_MASK;
    endcase
  end

  always_comb begin
    phase_step_next       = phase_step;
    transaction_kind_next = transaction_kind;
    active_next           = active;
    latched_device_next   = latched_device;
    latched_register_next = latched_register;
    latched_data_next     = latched_data;
    received_byte_next    = received_byte;
    ack_record_next       = ack_record;
    scl_level_next        = scl_level;
    sda_level_next        = sda_level;
    done_next             = 1'b0;

    if (in_q.func == FUNC_TICK) begin
      if (active) begin
        if (!seg.hit) begin
          active_next = 1'b0;
        end else begin
          phase_step_next = phase_step + 7'd1;
          unique case (seg.kind)
            SEG_START: begin
              case (seg.off[1:0])
                2'd0:    sda_level_next = 1'b1;
                2'd1:    scl_level_next = 1'b1;
                2'd2:    sda_level_next = 1'b0;
                default: scl_level_next = 1'b0;
              endcase
            end
            SEG_SEND: begin
              if (rem3 == 5'd0) begin
                sda_level_next = send_byte[3'd7 - bit_idx];
              end else begin
                scl_level_next = (rem3 == 5'd1);
              end
            end
            SEG_ACK: begin
              if (seg.off == 5'd0) begin
                sda_level_next = 1'b1;
              end else if (seg.off == 5'd1) begin
                scl_level_next = 1'b1;
              end else begin
                if (scl_level && in_q.sda_in) begin
                  ack_record_next[seg.arg] = 1'b1;
                end
                scl_level_next = 1'b0;
              end
            end
            SEG_RECV: begin
              if (seg.off == 5'd0) begin
                sda_level_next = 1'b1;
              end else if (!rx_k[0]) begin
                scl_level_next = 1'b1;
              end else begin
                if (scl_level && in_q.sda_in) begin
                  received_byte_next = received_byte | (MSB_MASK >> rx_bit);
                end
                scl_level_next = 1'b0;
              end
            end
            SEG_NACK: begin
              if (seg.off == 5'd0) sda_level_next = 1'b1;
              else scl_level_next = (seg.off == 5'd1);
            end
            SEG_STOP: begin
              if (seg.off == 5'd0) begin
                sda_level_next = 1'b0;
              end else if (seg.off == 5'd1) begin
                scl_level_next = 1'b1;
              end else begin
                sda_level_next  = 1'b1;
                active_next     = 1'b0;
                phase_step_next = 7'd0;
                done_next       = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
    end else if (in_q.func == FUNC_WRITE || in_q.func == FUNC_READ) begin
      // requests while a sequence runs are dropped
      if (!active) begin
        latched_device_next   = in_q.device_byte;
        latched_register_next = in_q.register_address;
        latched_data_next     = in_q.write_data;
        transaction_kind_next = (in_q.func == FUNC_READ) ? KIND_READ : KIND_WRITE;
        received_byte_next    = 8'd0;
        ack_record_next       = 3'd0;
        phase_step_next       = 7'd0;
        active_next           = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step       <= 7'd0;
      transaction_kind <= KIND_WRITE;
      active           <= 1'b0;
      latched_device   <= 8'd0;
      latched_register <= 8'd0;
      latched_data     <= 8'd0;
      received_byte    <= 8'd0;
      ack_record       <= 3'd0;
      scl_level        <= 1'b1;
      sda_level        <= 1'b1;
      out_valid        <= 1'b0;
    end else begin
      if (advance) begin
        phase_step       <= phase_step_next;
        transaction_kind <= transaction_kind_next;
        active           <= active_next;
        latched_device   <= latched_device_next;
        latched_register <= latched_register_next;
        latched_data     <= latched_data_next;
        received_byte    <= received_byte_next;
        ack_record       <= ack_record_next;
        scl_level        <= scl_level_next;
        sda_level        <= sda_level_next;
        out_valid        <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.scl_out   <= scl_level_next;
      out_data.sda_out   <= sda_level_next;
      out_data.busy_res  <= active_next;
      out_data.done_res  <= done_next;
      out_data.read_data <= received_byte_next;
      out_data.ack_bits  <= ack_record_next;
    end
  end

  // stop completion always leaves the bus released and the master idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.done_res |->
      !out_data.busy_res && out_data.scl_out && out_data.sda_out)
    else $error("done reported without idle, released bus");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    active |-> phase_step < 7'd112)
    else $error("phase step beyond read plan");

  a_write_range: assert property (@(posedge clk) disable iff (rst)
    active && transaction_kind == KIND_WRITE |-> phase_step < 7'd88)
    else $error("phase step beyond write plan");

  a_idle_step: assert property (@(posedge clk) disable iff (rst)
    $fell(active) && $past(in_vq) |-> phase_step == 7'd0)
    else $error("sequence ended without step clear");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the I2C register access master against a cycle-free model of its pin
// sequencing. Register writes and reads run phase by phase with fixed or random
// line levels on SDA. Busy requests and unused selectors are mixed in. Both sides
// of the block idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import i2cram_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // how sda_in is driven during a transaction
  localparam int SDA_LOW    = 0;
  localparam int SDA_HIGH   = 1;
  localparam int SDA_RANDOM = 2;

  localparam int RANDOM_ITEMS = 120;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  bit gaps_on = 1'b0;
  int error_count = 0;
  int items_sent = 0;
  int results_checked = 0;
  int writes_finished = 0;
  int reads_finished = 0;
  int refused_requests = 0;

  out_t pending_bus_states[$];

  // model state
  logic [6:0] m_step;
  logic       m_kind;
  logic       m_active;
  logic [7:0] m_dev;
  logic [7:0] m_reg;
  logic [7:0] m_data;
  logic [7:0] m_rx;
  logic [2:0] m_ack;
  logic       m_scl;
  logic       m_sda;

  i2c_register_access_master_unit uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #10 clk = ~clk;

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ------------------------------------------------------------------------
  // bus sequencing model
  // ------------------------------------------------------------------------
  function automatic int unsigned seg_length(input seg_kind_t kind);
    case (kind)
      SEG_START: return 4;
      SEG_SEND:  return 24;
      SEG_ACK:   return 3;
      SEG_RECV:  return 17;
      SEG_NACK:  return 3;
      default:   return 3;
    endcase
  endfunction

  function automatic void plan_entry(input logic rd, input int unsigned idx,
                                     output seg_kind_t kind, output logic [1:0] arg);
    arg = SRC_DEVICE;
    if (rd == KIND_WRITE) begin
      case (idx)
        0: kind = SEG_START;
        1: kind = SEG_SEND;
        2: kind = SEG_ACK;
        3: begin kind = SEG_SEND; arg = SRC_REGISTER; end
        4: begin kind = SEG_ACK;  arg = 2'd1; end
        5: begin kind = SEG_SEND; arg = SRC_DATA; end
        6: begin kind = SEG_ACK;  arg = 2'd2; end
        default: kind = SEG_STOP;
      endcase
    end else begin
      case (idx)
        0: kind = SEG_START;
        1: kind = SEG_SEND;
        2: kind = SEG_ACK;
        3: begin kind = SEG_SEND; arg = SRC_REGISTER; end
        4: begin kind = SEG_ACK;  arg = 2'd1; end
        5: kind = SEG_START;  // repeated start
        6: begin kind = SEG_SEND; arg = SRC_DEV_RD; end
        7: begin kind = SEG_ACK;  arg = 2'd2; end
        8: kind = SEG_RECV;
        9: kind = SEG_NACK;
        default: kind = SEG_STOP;
      endcase
    end
  endfunction

  function automatic logic [7:0] send_byte(input logic [1:0] src);
    case (src)
      SRC_DEVICE:   return m_dev;
      SRC_REGISTER: return m_reg;
      SRC_DATA:     return m_data;
      default:      return m_dev | RD_BIT_MASK;
    endcase
  endfunction

  // one pin phase; returns 1 on the tick that ends the stop condition
  function automatic logic advance_phase(input logic sda);
    seg_kind_t kind;
    logic [1:0] arg;
    int unsigned off, cnt, s, bitn, r;
    logic [7:0] b;
    off = {25'd0, m_step};
    cnt = (m_kind == KIND_READ) ? 11 : 8;
    kind = SEG_START;
    arg = SRC_DEVICE;
    for (s = 0; s < cnt; s++) begin
      plan_entry(m_kind, s, kind, arg);
      if (off < seg_length(kind)) break;
      off -= seg_length(kind);
    end
    if (s >= cnt) begin
      m_active = 1'b0;
      return 1'b0;
    end
    m_step = m_step + 7'd1;
    case (kind)
      SEG_START: begin
        if (off == 0) m_sda = 1'b1;
        else if (off == 1) m_scl = 1'b1;
        else if (off == 2) m_sda = 1'b0;
        else m_scl = 1'b0;
      end
      SEG_SEND: begin
        bitn = off / 3;
        r = off % 3;
        b = send_byte(arg);
        if (r == 0) m_sda = b[7 - bitn];
        else m_scl = (r == 1);
      end
      SEG_ACK: begin
        if (off == 0) m_sda = 1'b1;
        else if (off == 1) m_scl = 1'b1;
        else begin
          if (m_scl && sda) m_ack[arg] = 1'b1;
          m_scl = 1'b0;
        end
      end
      SEG_RECV: begin
        if (off == 0) begin
          m_sda = 1'b1;
        end else begin
          bitn = (off - 1) / 2;
          r = (off - 1) % 2;
          if (r == 0) begin
            m_scl = 1'b1;
          end else begin
            if (m_scl && sda) m_rx = m_rx | (MSB_MASK >> bitn);
            m_scl = 1'b0;
          end
        end
      end
      SEG_NACK: begin
        if (off == 0) m_sda = 1'b1;
        else m_scl = (off == 1);
      end
      default: begin
        if (off == 0) m_sda = 1'b0;
        else if (off == 1) m_scl = 1'b1;
        else begin
          m_sda = 1'b1;
          m_active = 1'b0;
          m_step = '0;
          if (m_kind == KIND_READ) reads_finished++;
          else writes_finished++;
          return 1'b1;
        end
      end
    endcase
    return 1'b0;
  endfunction

  function automatic out_t bus_model_step(input in_t item);
    out_t res;
    logic fin;
    fin = 1'b0;
    if (item.func == FUNC_TICK) begin
      if (m_active) fin = advance_phase(item.sda_in);
    end else if (item.func == FUNC_WRITE || item.func == FUNC_READ) begin
      if (!m_active) begin
        m_dev = item.device_byte;
        m_reg = item.register_address;
        m_data = item.write_data;
        m_kind = (item.func == FUNC_READ) ? KIND_READ : KIND_WRITE;
        m_rx = '0;
        m_ack = '0;
        m_step = '0;
        m_active = 1'b1;
      end else begin
        refused_requests++;
      end
    end
    res.scl_out = m_scl;
    res.sda_out = m_sda;
    res.busy_res = m_active;
    res.done_res = fin;
    res.read_data = m_rx;
    res.ack_bits = m_ack;
    return res;
  endfunction

  // ------------------------------------------------------------------------
  // driving
  // ------------------------------------------------------------------------
  function automatic in_t random_item();
    in_t item;
    item.func = FUNC_TICK;
    item.device_byte = 8'($urandom_range(0, 255));
    item.register_address = 8'($urandom_range(0, 255));
    item.write_data = 8'($urandom_range(0, 255));
    item.sda_in = 1'($urandom_range(0, 1));
    return item;
  endfunction

  task automatic send_item(input in_t item);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_bus_states.push_back(bus_model_step(item));
    items_sent++;
  endtask

  // request, then ticks until the model says the stop has completed
  task automatic run_transaction(input logic [1:0] req, input logic [7:0] dev,
                                 input logic [7:0] reg_a, input logic [7:0] data,
                                 input int sda_mode, input int noise_pct);
    in_t item;
    item = random_item();
    item.func = req;
    item.device_byte = dev;
    item.register_address = reg_a;
    item.write_data = data;
    send_item(item);
    while (m_active) begin
      item = random_item();
      if ($urandom_range(0, 99) < noise_pct) begin
        case ($urandom_range(0, 2))
          0: item.func = FUNC_WRITE;
          1: item.func = FUNC_READ;
          default: item.func = FUNC_UNUSED;
        endcase
      end
      if (sda_mode == SDA_LOW) item.sda_in = 1'b0;
      else if (sda_mode == SDA_HIGH) item.sda_in = 1'b1;
      send_item(item);
    end
  endtask

  task automatic idle_noise(input int count);
    in_t item;
    repeat (count) begin
      item = random_item();
      if ($urandom_range(0, 1) == 1) item.func = FUNC_UNUSED;
      send_item(item);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_bus_states.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic random_transaction(input int noise_pct);
    logic [1:0] req;
    int mode;
    req = ($urandom_range(0, 1) == 1) ? FUNC_READ : FUNC_WRITE;
    mode = ($urandom_range(0, 5) == 0) ? SDA_HIGH : SDA_RANDOM;
    run_transaction(req, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), mode, noise_pct);
  endtask

  // ------------------------------------------------------------------------
  // receiving side
  // ------------------------------------------------------------------------
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= 40) $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  always @(posedge clk) begin : check_results
    out_t want;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (pending_bus_states.size() == 0) begin
        report_mismatch("result transfer with nothing outstanding");
      end else begin
        want = pending_bus_states.pop_front();
        check_field("scl_out", 8'(out_data.scl_out), 8'(want.scl_out));
        check_field("sda_out", 8'(out_data.sda_out), 8'(want.sda_out));
        check_field("busy_res", 8'(out_data.busy_res), 8'(want.busy_res));
        check_field("done_res", 8'(out_data.done_res), 8'(want.done_res));
        check_field("read_data", out_data.read_data, want.read_data);
        check_field("ack_bits", 8'(out_data.ack_bits), 8'(want.ack_bits));
        results_checked++;
      end
    end
  end

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------
  task automatic test_idle_items();
    idle_noise(6);
  endtask

  task automatic test_write_extremes();
    run_transaction(FUNC_WRITE, 8'hFF, 8'hFF, 8'hFF, SDA_HIGH, 0);
    run_transaction(FUNC_WRITE, 8'h00, 8'h00, 8'h00, SDA_LOW, 0);
  endtask

  task automatic test_read_extremes();
    run_transaction(FUNC_READ, 8'h00, 8'hFF, 8'h00, SDA_HIGH, 0);
    run_transaction(FUNC_READ, 8'hFE, 8'h00, 8'hFF, SDA_LOW, 0);
    // read_data must clear again on the next write request
    run_transaction(FUNC_WRITE, 8'hA5, 8'h5A, 8'hC3, SDA_RANDOM, 0);
  endtask

  task automatic test_busy_requests();
    run_transaction(FUNC_READ, 8'hC2, 8'h18, 8'h99, SDA_RANDOM, 30);
  endtask

  task automatic test_random();
    int start_count;
    bit drained;
    start_count = items_sent;
    drained = 1'b0;
    gaps_on = 1'b1;
    while (items_sent - start_count < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) idle_noise($urandom_range(1, 4));
      else random_transaction(5);
      // hold the sender once until every result is back
      if (!drained && items_sent - start_count > RANDOM_ITEMS / 2) begin
        drain_results();
        drained = 1'b1;
      end
    end
  endtask

  task automatic test_back_to_back();
    gaps_on = 1'b0;
    random_transaction(5);
    idle_noise(3);
  endtask

  initial begin
    m_step = '0;
    m_kind = KIND_WRITE;
    m_active = 1'b0;
    m_dev = '0;
    m_reg = '0;
    m_data = '0;
    m_rx = '0;
    m_ack = '0;
    m_scl = 1'b1;
    m_sda = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_items();
    test_write_extremes();
    test_read_extremes();
    test_busy_requests();
    test_random();
    test_back_to_back();

    in_valid <= 1'b0;
    while (pending_bus_states.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d transfers in: %0d register writes, %0d register reads,",
             items_sent, writes_finished, reads_finished);
    $display("%0d requests refused while busy, %0d results compared.",
             refused_requests, results_checked);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
